[design/nwva_pkg.sv]
// Package for the windowed sample mean and range check unit.
// Holds widths, reset values, register indexes, shared structs and the back-end state type.
// No dependencies.
package nwva_pkg;

    localparam int SAMPLE_W      = 13;
    localparam int CFG_W         = 13;
    localparam int ALLOWED_W     = 4;
    localparam int OUT_CNT_W     = 4;
    localparam int OUT_CNT_MAX   = 15;
    localparam int STEP_W        = $clog2(SAMPLE_W);
    localparam int DEPTH_DEFAULT = 8;

    localparam logic [SAMPLE_W-1:0]  LOWER_RESET   = SAMPLE_W'(108);
    localparam logic [SAMPLE_W-1:0]  UPPER_RESET   = SAMPLE_W'(4460);
    localparam logic [ALLOWED_W-1:0] ALLOWED_RESET = ALLOWED_W'(1);
    localparam logic [SAMPLE_W-1:0]  START_RESET   = '0;

    typedef enum logic [1:0] {
        REG_LOWER_LIMIT,
        REG_UPPER_LIMIT,
        REG_ALLOWED_INVALID,
        REG_START_VALUE
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  lower_limit_mv;
        logic [SAMPLE_W-1:0]  upper_limit_mv;
        logic [ALLOWED_W-1:0] allowed_invalid;
        logic [SAMPLE_W-1:0]  start_value_mv;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_mv;
        logic                valid;
    } item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_TALLY,
        S_PREP,
        S_DIVIDE,
        S_DONE
    } back_state_t;

endpackage

[design/nwva_front.sv]
// Front end: configuration registers and range classification of incoming samples.
// Depends on nwva_pkg; feeds nwva_queue and hands the configuration to nwva_back.
module nwva_front
    import nwva_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                push,
    input  logic [SAMPLE_W-1:0] sample_mv,
    input  logic                q_full,
    output logic                full,
    output logic                q_push,
    output item_t               q_item,
    output cfg_t                cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_limit_mv  <= LOWER_RESET;
            cfg_reg.upper_limit_mv  <= UPPER_RESET;
            cfg_reg.allowed_invalid <= ALLOWED_RESET;
            cfg_reg.start_value_mv  <= START_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOWER_LIMIT:     cfg_reg.lower_limit_mv  <= cfg_wdata[SAMPLE_W-1:0];
                REG_UPPER_LIMIT:     cfg_reg.upper_limit_mv  <= cfg_wdata[SAMPLE_W-1:0];
                REG_ALLOWED_INVALID: cfg_reg.allowed_invalid <= cfg_wdata[ALLOWED_W-1:0];
                REG_START_VALUE:     cfg_reg.start_value_mv  <= cfg_wdata[SAMPLE_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg              = cfg_reg;
    assign full             = q_full;
    assign q_push           = push && !q_full;
    assign q_item.sample_mv = sample_mv;
    assign q_item.valid     = !((sample_mv < cfg_reg.lower_limit_mv) ||
                                (sample_mv > cfg_reg.upper_limit_mv));

endmodule

[design/nwva_queue.sv]
// Two-entry queue of classified samples between the front end and the back end.
// Depends on nwva_pkg for the item type.
module nwva_queue
    import nwva_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_push,
    input  item_t q_item,
    input  logic  q_pop,
    output logic  q_full,
    output logic  q_empty,
    output item_t q_head
);

    item_t      slot_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            slot_reg[wr_ptr_reg] <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (q_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (q_push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (q_pop && !q_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign q_head  = slot_reg[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue pointers disagree with count");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");

endmodule

[design/nwva_back.sv]
// Back end: sample ring, walk over the ring for counts and sum, serial divider, result register.
// Depends on nwva_pkg; takes items from nwva_queue and configuration from nwva_front.
module nwva_back
    import nwva_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_empty,
    input  item_t                q_head,
    output logic                 q_pop,
    input  logic                 pop,
    output logic                 empty,
    output logic                 sample_valid,
    output logic [OUT_CNT_W-1:0] invalid_count,
    output logic                 too_many_invalid,
    output logic [OUT_CNT_W-1:0] used_count,
    output logic [SAMPLE_W-1:0]  mean_mv,
    output logic                 no_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;

    logic [SAMPLE_W:0] ring_mem [DEPTH];
    logic [DEPTH-1:0]  written_reg, written_next;

    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  walk_idx_reg, walk_idx_next;
    logic              acc_vld_reg, acc_vld_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              res_full_reg, res_full_next;

    logic [SAMPLE_W:0]   rd_data_reg;
    logic                rd_written_reg;
    logic                cur_valid_reg, cur_valid_next;
    logic [CNT_W-1:0]    inv_cnt_reg, inv_cnt_next;
    logic [CNT_W-1:0]    used_cnt_reg, used_cnt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [SAMPLE_W-1:0] dvd_reg, dvd_next;

    logic                 res_valid_reg, res_valid_next;
    logic [OUT_CNT_W-1:0] res_inv_reg, res_inv_next;
    logic                 res_many_reg, res_many_next;
    logic [OUT_CNT_W-1:0] res_used_reg, res_used_next;
    logic [SAMPLE_W-1:0]  res_mean_reg, res_mean_next;
    logic                 res_nodata_reg, res_nodata_next;

    logic                ring_we;
    logic                rd_en;
    logic [SAMPLE_W-1:0] ent_val;
    logic                ent_inv;
    logic [CNT_W:0]      trial;
    logic                res_load;

    function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] n);
        logic [31:0] ext;
        ext = 32'(n);
        return (ext > 32'(OUT_CNT_MAX)) ? OUT_CNT_W'(OUT_CNT_MAX) : ext[OUT_CNT_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wr_ptr_reg] <= {!q_head.valid, q_head.sample_mv};
        end
        if (rd_en)
        begin
            rd_data_reg    <= ring_mem[walk_idx_reg];
            rd_written_reg <= written_reg[walk_idx_reg];
        end
    end

    assign ent_val = rd_written_reg ? rd_data_reg[SAMPLE_W-1:0] : '0;
    assign ent_inv = rd_written_reg && rd_data_reg[SAMPLE_W];
    assign trial   = {rem_reg, dvd_reg[SAMPLE_W-1]};

    always_comb
    begin
        state_next      = state_reg;
        wr_ptr_next     = wr_ptr_reg;
        walk_idx_next   = walk_idx_reg;
        acc_vld_next    = 1'b0;
        step_next       = step_reg;
        written_next    = written_reg;
        cur_valid_next  = cur_valid_reg;
        inv_cnt_next    = inv_cnt_reg;
        used_cnt_next   = used_cnt_reg;
        sum_next        = sum_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        res_load        = 1'b0;
        q_pop           = 1'b0;
        ring_we         = 1'b0;
        rd_en           = 1'b0;

        if (acc_vld_reg)
        begin
            if (ent_inv)
            begin
                inv_cnt_next = inv_cnt_reg + CNT_W'(1);
            end
            else if (ent_val != cfg.start_value_mv)
            begin
                used_cnt_next = used_cnt_reg + CNT_W'(1);
                sum_next      = sum_reg + SUM_W'(ent_val);
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop                    = 1'b1;
                    ring_we                  = 1'b1;
                    written_next[wr_ptr_reg] = 1'b1;
                    cur_valid_next           = q_head.valid;
                    wr_ptr_next              = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ?
                                               '0 : wr_ptr_reg + IDX_W'(1);
                    walk_idx_next            = '0;
                    inv_cnt_next             = '0;
                    used_cnt_next            = '0;
                    sum_next                 = '0;
                    state_next               = S_WALK;
                end
            end
            S_WALK:
            begin
                rd_en        = 1'b1;
                acc_vld_next = 1'b1;
                if (walk_idx_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = S_TALLY;
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + IDX_W'(1);
                end
            end
            S_TALLY:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                rem_next   = CNT_W'(sum_reg >> SAMPLE_W);
                dvd_next   = sum_reg[SAMPLE_W-1:0];
                step_next  = '0;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if ({1'b0, trial} >= {1'b0, 1'b0, used_cnt_reg})
                begin
                    rem_next = CNT_W'(trial - {1'b0, used_cnt_reg});
                    dvd_next = {dvd_reg[SAMPLE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CNT_W-1:0];
                    dvd_next = {dvd_reg[SAMPLE_W-2:0], 1'b0};
                end
                if (step_reg == STEP_W'(SAMPLE_W - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DONE:
            begin
                if (!res_full_reg || pop)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_valid_next  = cur_valid_reg;
        res_inv_next    = sat_cnt(inv_cnt_reg);
        res_many_next   = (32'(inv_cnt_reg) > 32'(cfg.allowed_invalid));
        res_used_next   = sat_cnt(used_cnt_reg);
        res_nodata_next = (used_cnt_reg == '0);
        res_mean_next   = (used_cnt_reg == '0) ? '0 : dvd_reg;

        res_full_next = res_full_reg;
        if (res_load)
        begin
            res_full_next = 1'b1;
        end
        else if (pop && res_full_reg)
        begin
            res_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wr_ptr_reg   <= '0;
            walk_idx_reg <= '0;
            acc_vld_reg  <= 1'b0;
            step_reg     <= '0;
            written_reg  <= '0;
            res_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wr_ptr_reg   <= wr_ptr_next;
            walk_idx_reg <= walk_idx_next;
            acc_vld_reg  <= acc_vld_next;
            step_reg     <= step_next;
            written_reg  <= written_next;
            res_full_reg <= res_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_valid_reg <= cur_valid_next;
        inv_cnt_reg   <= inv_cnt_next;
        used_cnt_reg  <= used_cnt_next;
        sum_reg       <= sum_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        if (res_load)
        begin
            res_valid_reg  <= res_valid_next;
            res_inv_reg    <= res_inv_next;
            res_many_reg   <= res_many_next;
            res_used_reg   <= res_used_next;
            res_mean_reg   <= res_mean_next;
            res_nodata_reg <= res_nodata_next;
        end
    end

    assign empty            = !res_full_reg;
    assign sample_valid     = res_valid_reg;
    assign invalid_count    = res_inv_reg;
    assign too_many_invalid = res_many_reg;
    assign used_count       = res_used_reg;
    assign mean_mv          = res_mean_reg;
    assign no_data          = res_nodata_reg;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!q_empty && state_reg == S_IDLE))
        else $error("queue popped while empty or busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP) |->
        (32'(inv_cnt_reg) + 32'(used_cnt_reg) <= 32'(DEPTH)))
        else $error("ring tally exceeds depth");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE && used_cnt_reg != '0) |-> (rem_reg < used_cnt_reg))
        else $error("divider remainder out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_full_reg || pop))
        else $error("result overwritten before transfer");

endmodule

[design/ntc_window_validity_average_unit.sv]
// Windowed sample mean with range validity check, top level.
// A new item is taken from the queue only once the last result is loaded; the pace is
// set by the walk over the sample ring (one entry a cycle) and the 13-step serial divider.
// Reset: asynchronous active low; ring reads as zero/valid; control and config regs reset.
// Depends on nwva_pkg, nwva_front, nwva_queue and nwva_back.
module ntc_window_validity_average_unit
    import nwva_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  logic [SAMPLE_W-1:0]  sample_mv,
    input  logic                 pop,
    output logic                 empty,
    output logic                 sample_valid,
    output logic [OUT_CNT_W-1:0] invalid_count,
    output logic                 too_many_invalid,
    output logic [OUT_CNT_W-1:0] used_count,
    output logic [SAMPLE_W-1:0]  mean_mv,
    output logic                 no_data
);

    cfg_t  cfg;
    item_t q_item;
    item_t q_head;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    nwva_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .sample_mv (sample_mv),
        .q_full    (q_full),
        .full      (full),
        .q_push    (q_push),
        .q_item    (q_item),
        .cfg       (cfg)
    );

    nwva_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .q_full  (q_full),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    nwva_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .pop              (pop),
        .empty            (empty),
        .sample_valid     (sample_valid),
        .invalid_count    (invalid_count),
        .too_many_invalid (too_many_invalid),
        .used_count       (used_count),
        .mean_mv          (mean_mv),
        .no_data          (no_data)
    );

endmodule
